### hw/rtl/indexed_vertex_list_macros.svh
// ----------------------------------------------------------------------------
// Indexed vertex list assertion macros
// Shared concurrent assertion forms for the vertex list block.
// ----------------------------------------------------------------------------
`ifndef INDEXED_VERTEX_LIST_MACROS_SVH
`define INDEXED_VERTEX_LIST_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define IVL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define IVL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/ivl_pkg.sv
// ----------------------------------------------------------------------------
// Indexed vertex list package
// Sizes, codes, cell control types and coordinate conversions.
// ----------------------------------------------------------------------------
package ivl_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int COORD_WIDTH  = 16;
   localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
   localparam int FIELD_W      = 16;
   localparam int POS_W        = 7;
   localparam int KIND_W       = 3;
   localparam int ECOUNT_W     = 7;
   localparam int CMP_W        = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT = 3'd0,
      KIND_DELETE = 3'd1,
      KIND_READ   = 3'd2,
      KIND_DUMP   = 3'd3,
      KIND_CLEAR  = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_FULL  = 2'd2,
      STAT_EMPTY = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_ROTATE
   } cell_op_type;

   typedef struct packed {
      logic [COORD_WIDTH-1:0] x;
      logic [COORD_WIDTH-1:0] y;
   } vtx_type;

   // Broadcast control for every cell of the row.
   typedef struct packed {
      cell_op_type      op;
      logic [CNT_W-1:0] pos;
      logic [CNT_W-1:0] tail;
      vtx_type          fresh;
   } cell_ctl_type;

   // Sign-extend a 16-bit field and keep the stored width.
   function automatic logic [COORD_WIDTH-1:0] to_store(input logic signed [FIELD_W-1:0] v);
      logic [31:0] ext;
      ext = 32'(v);
      return ext[COORD_WIDTH-1:0];
   endfunction

   // Sign-extend a stored coordinate and cut it to the 16-bit field.
   function automatic logic [FIELD_W-1:0] to_field(input logic [COORD_WIDTH-1:0] s);
      logic [31:0] ext;
      ext = 32'(signed'(s));
      return ext[FIELD_W-1:0];
   endfunction

endpackage

### hw/rtl/ivl_cell.sv
// ----------------------------------------------------------------------------
// Vertex list cell
// Holds one vertex and moves it to or from its neighbors on command.
// ----------------------------------------------------------------------------
module ivl_cell (
   input  logic                        clock,
   input  ivl_pkg::cell_ctl_type       ctl,
   input  logic [ivl_pkg::CNT_W-1:0]   idx,
   input  ivl_pkg::vtx_type            from_left,
   input  ivl_pkg::vtx_type            from_right,
   input  ivl_pkg::vtx_type            from_head,
   output ivl_pkg::vtx_type            data
);

   ivl_pkg::vtx_type data_ff;
   ivl_pkg::vtx_type data_in;

   // Each cell decides locally from its own position.
   always_comb begin
      data_in = data_ff;
      case (ctl.op)
         ivl_pkg::CELL_INSERT: begin
            if (idx > ctl.pos) begin
               data_in = from_left;
            end else if (idx == ctl.pos) begin
               data_in = ctl.fresh;
            end
         end
         ivl_pkg::CELL_DELETE: begin
            if (idx >= ctl.pos) begin
               data_in = from_right;
            end
         end
         ivl_pkg::CELL_ROTATE: begin
            if (idx == ctl.tail) begin
               data_in = from_head;
            end else begin
               data_in = from_right;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

### hw/rtl/ivl_chain.sv
// ----------------------------------------------------------------------------
// Vertex list cell row
// A row of cells; entry 0 is the front and is the only one read out.
// ----------------------------------------------------------------------------
module ivl_chain (
   input  logic                   clock,
   input  ivl_pkg::cell_ctl_type  ctl,
   output ivl_pkg::vtx_type       head
);

   ivl_pkg::vtx_type cell_data [ivl_pkg::MAX_VERTICES];

   // Build the row; the front cell takes the fresh vertex from the left,
   // and the back cell sees the front as its right neighbor.
   for (genvar i = 0; i < ivl_pkg::MAX_VERTICES; i++) begin : g_cell
      ivl_pkg::vtx_type left_data;
      ivl_pkg::vtx_type right_data;

      if (i == 0) begin : g_front
         assign left_data = ctl.fresh;
      end else begin : g_inner_left
         assign left_data = cell_data[i-1];
      end

      if (i == ivl_pkg::MAX_VERTICES - 1) begin : g_back
         assign right_data = cell_data[0];
      end else begin : g_inner_right
         assign right_data = cell_data[i+1];
      end

      ivl_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .idx        (ivl_pkg::CNT_W'(i)),
         .from_left  (left_data),
         .from_right (right_data),
         .from_head  (cell_data[0]),
         .data       (cell_data[i])
      );
   end

   assign head = cell_data[0];

endmodule

### hw/rtl/indexed_vertex_list.sv
// ----------------------------------------------------------------------------
// Indexed vertex list
// Ordered list of signed coordinate pairs with insert, delete, read, dump
// and clear requests.
// ----------------------------------------------------------------------------
// The list lives in a row of cells, one vertex per cell, and every cell moves
// its vertex in the same cycle. Insert, delete, clear, unused kinds and every
// error are answered from the output register, so these can follow each
// other in consecutive cycles while rsp_ready is high. Read and dump rotate
// the held entries through the front cell once, one step per cycle, so they
// hold the request side for the accepting cycle plus entry_count rotation
// cycles (plus any cycles in which rsp_ready is low while a response is
// waiting); the rotation leaves the list in its original order.
// A dump returns one response per entry, the last one flagged by rsp_last.
// No new request is taken during a rotation.

`include "indexed_vertex_list_macros.svh"

module indexed_vertex_list (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [ivl_pkg::KIND_W-1:0]      req_kind,
   input  logic [ivl_pkg::POS_W-1:0]       req_position,
   input  logic signed [ivl_pkg::FIELD_W-1:0] req_coord_x,
   input  logic signed [ivl_pkg::FIELD_W-1:0] req_coord_y,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_status,
   output logic signed [ivl_pkg::FIELD_W-1:0] rsp_out_x,
   output logic signed [ivl_pkg::FIELD_W-1:0] rsp_out_y,
   output logic [ivl_pkg::ECOUNT_W-1:0]    rsp_entry_count,
   output logic                            rsp_last
);

   typedef enum logic {
      S_IDLE,
      S_ROTATE
   } state_type;

   state_type                         state_ff,  state_in;
   logic [ivl_pkg::CNT_W-1:0]         count_ff,  count_in;
   logic [ivl_pkg::CNT_W-1:0]         step_ff,   step_in;
   logic [ivl_pkg::CNT_W-1:0]         rpos_ff,   rpos_in;
   logic                              dump_ff,   dump_in;
   logic                              rvalid_ff, rvalid_in;
   logic [1:0]                        rstat_ff,  rstat_in;
   logic [ivl_pkg::FIELD_W-1:0]       rx_ff,     rx_in;
   logic [ivl_pkg::FIELD_W-1:0]       ry_ff,     ry_in;
   logic [ivl_pkg::ECOUNT_W-1:0]      rcount_ff, rcount_in;
   logic                              rlast_ff,  rlast_in;

   logic                              slot_free;
   logic                              accept;
   logic [ivl_pkg::CMP_W-1:0]         pos_cmp;
   logic [ivl_pkg::CMP_W-1:0]         cnt_cmp;
   logic [ivl_pkg::CNT_W-1:0]         tail;
   ivl_pkg::cell_ctl_type             ctl;
   ivl_pkg::vtx_type                  head;

   logic                              count_in_bound;
   logic                              rotating;
   logic                              dump_start;

   // Handshake: the output register frees up when it is empty or being taken.
   assign slot_free = !rvalid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;

   assign pos_cmp = ivl_pkg::CMP_W'(req_position);
   assign cnt_cmp = ivl_pkg::CMP_W'(count_ff);
   assign tail    = count_ff - ivl_pkg::CNT_W'(1);

   // Request decode, rotation sequencing and response formation.
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      step_in   = step_ff;
      rpos_in   = rpos_ff;
      dump_in   = dump_ff;
      rvalid_in = rvalid_ff && !rsp_ready;
      rstat_in  = rstat_ff;
      rx_in     = rx_ff;
      ry_in     = ry_ff;
      rcount_in = rcount_ff;
      rlast_in  = rlast_ff;

      ctl.op          = ivl_pkg::CELL_HOLD;
      ctl.pos         = ivl_pkg::CNT_W'(req_position);
      ctl.tail        = tail;
      ctl.fresh.x     = ivl_pkg::to_store(req_coord_x);
      ctl.fresh.y     = ivl_pkg::to_store(req_coord_y);

      if (accept) begin
         // Default single response; overridden for rotations.
         rvalid_in = 1'b1;
         rstat_in  = ivl_pkg::STAT_OK;
         rx_in     = '0;
         ry_in     = '0;
         rlast_in  = 1'b1;
         case (req_kind)
            ivl_pkg::KIND_INSERT: begin
               if (pos_cmp > cnt_cmp) begin
                  rstat_in = ivl_pkg::STAT_RANGE;
               end else if (count_ff == ivl_pkg::CNT_W'(ivl_pkg::MAX_VERTICES)) begin
                  rstat_in = ivl_pkg::STAT_FULL;
               end else begin
                  ctl.op   = ivl_pkg::CELL_INSERT;
                  count_in = count_ff + ivl_pkg::CNT_W'(1);
               end
            end
            ivl_pkg::KIND_DELETE: begin
               if (pos_cmp >= cnt_cmp) begin
                  rstat_in = ivl_pkg::STAT_RANGE;
               end else begin
                  ctl.op   = ivl_pkg::CELL_DELETE;
                  count_in = tail;
               end
            end
            ivl_pkg::KIND_READ: begin
               if (pos_cmp >= cnt_cmp) begin
                  rstat_in = ivl_pkg::STAT_RANGE;
               end else begin
                  rvalid_in = 1'b0;
                  state_in  = S_ROTATE;
                  step_in   = '0;
                  rpos_in   = ivl_pkg::CNT_W'(req_position);
                  dump_in   = 1'b0;
               end
            end
            ivl_pkg::KIND_DUMP: begin
               if (count_ff == '0) begin
                  rstat_in = ivl_pkg::STAT_EMPTY;
               end else begin
                  rvalid_in = 1'b0;
                  state_in  = S_ROTATE;
                  step_in   = '0;
                  dump_in   = 1'b1;
               end
            end
            ivl_pkg::KIND_CLEAR: begin
               count_in = '0;
            end
            default: begin
               rstat_in = ivl_pkg::STAT_OK;
            end
         endcase
         rcount_in = ivl_pkg::ECOUNT_W'(count_in);
      end else if (state_ff == S_ROTATE && slot_free) begin
         // One rotation step; the front vertex is the entry at this step.
         ctl.op  = ivl_pkg::CELL_ROTATE;
         step_in = step_ff + ivl_pkg::CNT_W'(1);
         if (dump_ff || step_ff == rpos_ff) begin
            rvalid_in = 1'b1;
            rstat_in  = ivl_pkg::STAT_OK;
            rx_in     = ivl_pkg::to_field(head.x);
            ry_in     = ivl_pkg::to_field(head.y);
            rcount_in = ivl_pkg::ECOUNT_W'(count_ff);
            rlast_in  = dump_ff ? (step_ff == tail) : 1'b1;
         end
         if (step_ff == tail) begin
            state_in = S_IDLE;
         end
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         step_ff   <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         step_ff   <= step_in;
         rvalid_ff <= rvalid_in;
      end
      rpos_ff   <= rpos_in;
      dump_ff   <= dump_in;
      rstat_ff  <= rstat_in;
      rx_ff     <= rx_in;
      ry_ff     <= ry_in;
      rcount_ff <= rcount_in;
      rlast_ff  <= rlast_in;
   end

   ivl_chain u_chain (
      .clock (clock),
      .ctl   (ctl),
      .head  (head)
   );

   assign rsp_valid       = rvalid_ff;
   assign rsp_status      = rstat_ff;
   assign rsp_out_x       = rx_ff;
   assign rsp_out_y       = ry_ff;
   assign rsp_entry_count = rcount_ff;
   assign rsp_last        = rlast_ff;

   // Conditions watched by the checks below.
   assign count_in_bound = count_ff <= ivl_pkg::CNT_W'(ivl_pkg::MAX_VERTICES);
   assign rotating       = state_ff == S_ROTATE;
   assign dump_start     = accept && (req_kind == ivl_pkg::KIND_DUMP) && (count_ff != '0);

   // The list never holds more entries than it has cells.
   `IVL_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_in_bound, "count above capacity")
   // A rotation never changes the number of entries.
   `IVL_ASSERT_NEXT(a_rotate_count, clock, reset, rotating, $stable(count_ff), "count moved")
   // A dump of a non-empty list starts a rotation.
   `IVL_ASSERT_NEXT(a_dump_rotates, clock, reset, dump_start, rotating, "dump did not rotate")

endmodule

### verif/indexed_vertex_list_tb.sv
// ----------------------------------------------------------------------------
// Indexed vertex list testbench
// Drives insert, delete, read, dump, clear and unused-kind requests into the
// vertex list with random gaps on both channels. A scoreboard keeps its own
// copy of the list, predicts each response and checks it field by field.
// ----------------------------------------------------------------------------
module indexed_vertex_list_tb;

   // Kinds the block does not define still answer with one OK response.
   localparam logic [ivl_pkg::KIND_W-1:0] KIND_UNUSED_LO  = 3'd5;
   localparam logic [ivl_pkg::KIND_W-1:0] KIND_UNUSED_MID = 3'd6;
   localparam logic [ivl_pkg::KIND_W-1:0] KIND_UNUSED_HI  = 3'd7;
   localparam int HOLD_CYCLES   = 240;
   localparam int DRAIN_CYCLES  = 80;

   typedef struct packed {
      ivl_pkg::status_type                status;
      logic [ivl_pkg::FIELD_W-1:0]        x;
      logic [ivl_pkg::FIELD_W-1:0]        y;
      logic [ivl_pkg::ECOUNT_W-1:0]       count;
      logic                               last;
   } vertex_answer_type;

   // Scoreboard: holds its own copy of the list and the responses still due.
   class vertex_list_checker;
      logic [ivl_pkg::COORD_WIDTH-1:0] xs [ivl_pkg::MAX_VERTICES];
      logic [ivl_pkg::COORD_WIDTH-1:0] ys [ivl_pkg::MAX_VERTICES];
      int unsigned       held;
      vertex_answer_type answers_due [$];
      int errors;
      int requests;
      int responses;
      int dumps;
      int full_rejects;
      int range_rejects;
      int peak_held;

      function new();
         held          = 0;
         errors        = 0;
         requests      = 0;
         responses     = 0;
         dumps         = 0;
         full_rejects  = 0;
         range_rejects = 0;
         peak_held     = 0;
      endfunction

      // A 16-bit input coordinate is sign-extended and cut to the stored width.
      function logic [ivl_pkg::COORD_WIDTH-1:0] narrow_coord(
            input logic signed [ivl_pkg::FIELD_W-1:0] v);
         logic signed [31:0] wide;
         wide = 32'(v);
         return wide[ivl_pkg::COORD_WIDTH-1:0];
      endfunction

      // A stored coordinate is sign-extended and cut to the 16-bit field.
      function logic [ivl_pkg::FIELD_W-1:0] widen_coord(
            input logic [ivl_pkg::COORD_WIDTH-1:0] s);
         logic signed [ivl_pkg::COORD_WIDTH-1:0] sv;
         logic signed [31:0] wide;
         sv   = s;
         wide = 32'(sv);
         return wide[ivl_pkg::FIELD_W-1:0];
      endfunction

      function void queue_answer(input ivl_pkg::status_type st,
                                 input logic [ivl_pkg::FIELD_W-1:0] x,
                                 input logic [ivl_pkg::FIELD_W-1:0] y, input logic fin);
         vertex_answer_type a;
         a.status = st;
         a.x      = x;
         a.y      = y;
         a.count  = held[ivl_pkg::ECOUNT_W-1:0];
         a.last   = fin;
         answers_due.push_back(a);
         if (st == ivl_pkg::STAT_FULL) full_rejects++;
         if (st == ivl_pkg::STAT_RANGE) range_rejects++;
      endfunction

      // Update the list for one accepted request and queue its responses.
      function void note_request(input logic [ivl_pkg::KIND_W-1:0] kind,
                                 input logic [ivl_pkg::POS_W-1:0] position,
                                 input logic signed [ivl_pkg::FIELD_W-1:0] cx,
                                 input logic signed [ivl_pkg::FIELD_W-1:0] cy);
         int unsigned p;
         int unsigned i;
         p = 32'(position);
         requests++;
         case (kind)
            ivl_pkg::KIND_INSERT: begin
               if (p > held) begin
                  queue_answer(ivl_pkg::STAT_RANGE, '0, '0, 1'b1);
               end else if (held >= ivl_pkg::MAX_VERTICES) begin
                  queue_answer(ivl_pkg::STAT_FULL, '0, '0, 1'b1);
               end else begin
                  for (i = held; i > p; i--) begin
                     xs[i] = xs[i-1];
                     ys[i] = ys[i-1];
                  end
                  xs[p] = narrow_coord(cx);
                  ys[p] = narrow_coord(cy);
                  held++;
                  if (held > peak_held) peak_held = held;
                  queue_answer(ivl_pkg::STAT_OK, '0, '0, 1'b1);
               end
            end
            ivl_pkg::KIND_DELETE: begin
               if (p >= held) begin
                  queue_answer(ivl_pkg::STAT_RANGE, '0, '0, 1'b1);
               end else begin
                  for (i = p; i + 1 < held; i++) begin
                     xs[i] = xs[i+1];
                     ys[i] = ys[i+1];
                  end
                  held--;
                  queue_answer(ivl_pkg::STAT_OK, '0, '0, 1'b1);
               end
            end
            ivl_pkg::KIND_READ: begin
               if (p >= held)
                  queue_answer(ivl_pkg::STAT_RANGE, '0, '0, 1'b1);
               else
                  queue_answer(ivl_pkg::STAT_OK, widen_coord(xs[p]), widen_coord(ys[p]),
                               1'b1);
            end
            ivl_pkg::KIND_DUMP: begin
               dumps++;
               if (held == 0) begin
                  queue_answer(ivl_pkg::STAT_EMPTY, '0, '0, 1'b1);
               end else begin
                  for (i = 0; i < held; i++)
                     queue_answer(ivl_pkg::STAT_OK, widen_coord(xs[i]), widen_coord(ys[i]),
                                  i + 1 == held);
               end
            end
            ivl_pkg::KIND_CLEAR: begin
               held = 0;
               queue_answer(ivl_pkg::STAT_OK, '0, '0, 1'b1);
            end
            default: begin
               queue_answer(ivl_pkg::STAT_OK, '0, '0, 1'b1);
            end
         endcase
      endfunction

      function void report_field(input string field, input logic [ivl_pkg::FIELD_W-1:0] want,
                                 input logic [ivl_pkg::FIELD_W-1:0] got);
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         errors++;
      endfunction

      // Compare one accepted response with the oldest one due.
      function void check_response(input logic [1:0] status,
                                   input logic [ivl_pkg::FIELD_W-1:0] x,
                                   input logic [ivl_pkg::FIELD_W-1:0] y,
                                   input logic [ivl_pkg::ECOUNT_W-1:0] count,
                                   input logic last);
         vertex_answer_type want;
         responses++;
         if (answers_due.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual status %0d x %0h y %0h",
                     $time, status, x, y);
            errors++;
            return;
         end
         want = answers_due.pop_front();
         if (status !== want.status)
            report_field("status", ivl_pkg::FIELD_W'(want.status), ivl_pkg::FIELD_W'(status));
         if (x !== want.x) report_field("out_x", want.x, x);
         if (y !== want.y) report_field("out_y", want.y, y);
         if (count !== want.count)
            report_field("entry_count", ivl_pkg::FIELD_W'(want.count),
                         ivl_pkg::FIELD_W'(count));
         if (last !== want.last)
            report_field("last", ivl_pkg::FIELD_W'(want.last), ivl_pkg::FIELD_W'(last));
      endfunction
   endclass

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic [ivl_pkg::KIND_W-1:0]          req_kind;
   logic [ivl_pkg::POS_W-1:0]           req_position;
   logic signed [ivl_pkg::FIELD_W-1:0]  req_coord_x;
   logic signed [ivl_pkg::FIELD_W-1:0]  req_coord_y;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic [1:0]                          rsp_status;
   logic signed [ivl_pkg::FIELD_W-1:0]  rsp_out_x;
   logic signed [ivl_pkg::FIELD_W-1:0]  rsp_out_y;
   logic [ivl_pkg::ECOUNT_W-1:0]        rsp_entry_count;
   logic                                rsp_last;

   vertex_list_checker book;
   int   send_idle_pct;
   int   recv_idle_pct;
   logic hold_armed;
   logic hold_taken = 1'b0;
   int   hold_left  = 0;

   indexed_vertex_list dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_position    (req_position),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_entry_count (rsp_entry_count),
      .rsp_last        (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit, far above the slowest legal run.
   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // Response side: check accepted responses, then pick the next ready value.
   // A single long hold-off is counted down here once the main flow arms it.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         book.check_response(rsp_status, rsp_out_x, rsp_out_y, rsp_entry_count, rsp_last);
      if (hold_armed && !hold_taken) begin
         hold_left  = HOLD_CYCLES;
         hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Mostly random coordinates, with the extremes mixed in now and then.
   function automatic logic [ivl_pkg::FIELD_W-1:0] pick_coord();
      if ($urandom_range(9) != 0) return ivl_pkg::FIELD_W'($urandom);
      case ($urandom_range(3))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         2:       return 16'h0000;
         default: return 16'hffff;
      endcase
   endfunction

   // Offer one request after an optional gap and wait until it is taken.
   task automatic send_request(input logic [ivl_pkg::KIND_W-1:0] kind,
                               input logic [ivl_pkg::POS_W-1:0] position,
                               input logic [ivl_pkg::FIELD_W-1:0] cx,
                               input logic [ivl_pkg::FIELD_W-1:0] cy);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_position <= position;
      req_coord_x  <= cx;
      req_coord_y  <= cy;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      book.note_request(kind, position, cx, cy);
   endtask

   // Random traffic, mostly in-range positions so the list grows and shrinks.
   task automatic send_mixed(input int n);
      int roll;
      logic [ivl_pkg::KIND_W-1:0] k;
      logic [ivl_pkg::POS_W-1:0]  p;
      repeat (n) begin
         roll = $urandom_range(99);
         p    = ivl_pkg::POS_W'($urandom_range(127));
         if (roll < 35) begin
            k = ivl_pkg::KIND_INSERT;
            if ($urandom_range(9) != 0) p = ivl_pkg::POS_W'($urandom_range(book.held));
         end else if (roll < 50) begin
            k = ivl_pkg::KIND_DELETE;
            if (book.held != 0 && $urandom_range(6) != 0)
               p = ivl_pkg::POS_W'($urandom_range(book.held - 1));
         end else if (roll < 70) begin
            k = ivl_pkg::KIND_READ;
            if (book.held != 0 && $urandom_range(6) != 0)
               p = ivl_pkg::POS_W'($urandom_range(book.held - 1));
         end else if (roll < 78) begin
            k = ivl_pkg::KIND_DUMP;
         end else if (roll < 81) begin
            k = ivl_pkg::KIND_CLEAR;
         end else if (roll < 85) begin
            k = ivl_pkg::KIND_W'($urandom_range(KIND_UNUSED_HI, KIND_UNUSED_LO));
         end else begin
            k = ivl_pkg::KIND_W'($urandom_range(7));
         end
         send_request(k, p, pick_coord(), pick_coord());
      end
   endtask

   initial begin
      book          = new();
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_kind      = ivl_pkg::KIND_CLEAR;
      req_position  = '0;
      req_coord_x   = '0;
      req_coord_y   = '0;
      hold_armed    = 1'b0;
      send_idle_pct = 24;
      recv_idle_pct = 69;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty-list errors, inserts at front, middle and end,
      // reads, out-of-range positions, dumps, deletes, unused kinds, clear.
      send_request(ivl_pkg::KIND_DUMP,   7'd0,   16'h0000, 16'h0000);
      send_request(ivl_pkg::KIND_READ,   7'd0,   16'h0000, 16'h0000);
      send_request(ivl_pkg::KIND_DELETE, 7'd0,   16'h0000, 16'h0000);
      send_request(ivl_pkg::KIND_INSERT, 7'd1,   16'h1234, 16'h5678);
      send_request(ivl_pkg::KIND_INSERT, 7'd0,   16'h8000, 16'h7fff);
      send_request(ivl_pkg::KIND_INSERT, 7'd1,   16'h7fff, 16'h8000);
      send_request(ivl_pkg::KIND_INSERT, 7'd0,   16'h0000, 16'hffff);
      send_request(ivl_pkg::KIND_INSERT, 7'd1,   16'hffff, 16'h0000);
      send_request(ivl_pkg::KIND_READ,   7'd0,   16'h0000, 16'h0000);
      send_request(ivl_pkg::KIND_READ,   7'd1,   16'h0000, 16'h0000);
      send_request(ivl_pkg::KIND_READ,   7'd2,   16'h0000, 16'h0000);
      send_request(ivl_pkg::KIND_READ,   7'd3,   16'h0000, 16'h0000);
      send_request(ivl_pkg::KIND_READ,   7'd4,   16'h0000, 16'h0000);
      send_request(ivl_pkg::KIND_READ,   7'd127, 16'h0000, 16'h0000);
      send_request(ivl_pkg::KIND_DELETE, 7'd127, 16'h0000, 16'h0000);
      send_request(ivl_pkg::KIND_INSERT, 7'd127, 16'haaaa, 16'h5555);
      send_request(ivl_pkg::KIND_DUMP,   7'd0,   16'h0000, 16'h0000);
      send_request(ivl_pkg::KIND_DELETE, 7'd1,   16'h0000, 16'h0000);
      send_request(ivl_pkg::KIND_DELETE, 7'd2,   16'h0000, 16'h0000);
      send_request(ivl_pkg::KIND_DELETE, 7'd0,   16'h0000, 16'h0000);
      send_request(ivl_pkg::KIND_DUMP,   7'd0,   16'h0000, 16'h0000);
      send_request(KIND_UNUSED_LO,       7'd3,   16'hffff, 16'hffff);
      send_request(KIND_UNUSED_MID,      7'd64,  16'h0000, 16'h0000);
      send_request(KIND_UNUSED_HI,       7'd0,   16'h0000, 16'h0000);
      send_request(ivl_pkg::KIND_CLEAR,  7'd0,   16'h0000, 16'h0000);
      send_request(ivl_pkg::KIND_DUMP,   7'd0,   16'h0000, 16'h0000);
      send_request(ivl_pkg::KIND_INSERT, 7'd0,   16'h5555, 16'haaaa);

      send_mixed(75);

      // Second phase: the sender idles more than the receiver.
      send_idle_pct = 69;
      recv_idle_pct <= 24;

      // Fill the list to the top, then push against the full list.
      send_request(ivl_pkg::KIND_CLEAR, 7'd0, 16'h0000, 16'h0000);
      while (book.held < ivl_pkg::MAX_VERTICES)
         send_request(ivl_pkg::KIND_INSERT, ivl_pkg::POS_W'($urandom_range(book.held)),
                      pick_coord(), pick_coord());
      repeat (3)
         send_request(ivl_pkg::KIND_INSERT,
                      ivl_pkg::POS_W'($urandom_range(ivl_pkg::MAX_VERTICES - 1)),
                      pick_coord(), pick_coord());
      send_request(ivl_pkg::KIND_INSERT, 7'd64, 16'h0001, 16'h0002);
      send_request(ivl_pkg::KIND_INSERT, 7'd65, 16'h0001, 16'h0002);
      send_request(ivl_pkg::KIND_READ,   7'd63, 16'h0000, 16'h0000);
      send_request(ivl_pkg::KIND_READ,   7'd64, 16'h0000, 16'h0000);
      send_request(ivl_pkg::KIND_DUMP,   7'd0,  16'h0000, 16'h0000);
      send_request(ivl_pkg::KIND_DELETE, 7'd63, 16'h0000, 16'h0000);
      send_request(ivl_pkg::KIND_DELETE, 7'd0,  16'h0000, 16'h0000);
      send_mixed(30);

      // Third phase: no idling, with one long receiver hold-off up front
      // so that the block backs up and stalls its request side.
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      hold_armed    <= 1'b1;
      repeat (24)
         send_request(ivl_pkg::KIND_INSERT, ivl_pkg::POS_W'($urandom_range(book.held)),
                      pick_coord(), pick_coord());
      send_mixed(80);

      req_valid <= 1'b0;
      while (book.answers_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests and checked %0d responses, including %0d dumps.",
               book.requests, book.responses, book.dumps);
      $display("Peak list size %0d, %0d full-list and %0d out-of-range rejections.",
               book.peak_held, book.full_rejects, book.range_rejects);
      if (book.errors == 0 && book.answers_due.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/ivl_pkg.sv
hw/rtl/ivl_cell.sv
hw/rtl/ivl_chain.sv
hw/rtl/indexed_vertex_list.sv
verif/indexed_vertex_list_tb.sv
